// ----- hw/rtl/dema_pkg.sv -----
// ----------------------------------------------------------------------------
// dema_pkg
// Shared types and constants for the dual moving-average rate statistics block.
// ----------------------------------------------------------------------------
package dema_pkg;

  // Default field widths
  localparam int DEMA_RATE_BITS  = 10;
  localparam int DEMA_COUNT_BITS = 32;
  localparam int DEMA_FRAC_BITS  = 16;

  // Alpha weights are Q0.16, register is 17 bits so that 1.0 fits
  localparam int ALPHA_BITS = 16;
  localparam int ALPHA_HALF = 32768;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0]  CFG_ALPHA_SHORT = 1'b0;
  localparam logic [CFG_IDX_W-1:0]  CFG_ALPHA_LONG  = 1'b1;

  localparam logic [CFG_DATA_W-1:0] ALPHA_ONE        = 17'h10000;
  localparam logic [CFG_DATA_W-1:0] ALPHA_SHORT_RST  = 17'd21845;
  localparam logic [CFG_DATA_W-1:0] ALPHA_LONG_RST   = 17'd4228;

  // Request codes
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_S,
    ST_MUL_L,
    ST_UPD_L,
    ST_DIV,
    ST_OUT
  } dema_state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;      // request accepted this cycle
    logic mul_s;     // short product, divider init
    logic mul_l;     // short update, long product
    logic upd_l;     // long update
    logic div_step;  // one quotient bit
    logic out_load;  // capture result register
  } dema_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;
  } dema_sts_t;

endpackage

// ----- hw/rtl/dema_req_if.sv -----
// ----------------------------------------------------------------------------
// dema_req_if
// Request channel: sample or clear request with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dema_req_if import dema_pkg::*; #(
  parameter int RATE_BITS = DEMA_RATE_BITS
);
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [RATE_BITS-1:0] sample_rate;

  modport source (output valid, output req_type, output sample_rate, input ready);
  modport sink   (input valid, input req_type, input sample_rate, output ready);
endinterface

// ----- hw/rtl/dema_stats_if.sv -----
// ----------------------------------------------------------------------------
// dema_stats_if
// Result channel: averages and session statistics with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dema_stats_if import dema_pkg::*; #(
  parameter int RATE_BITS = DEMA_RATE_BITS
);
  logic                 valid;
  logic                 ready;
  logic [RATE_BITS-1:0] short_avg;
  logic [RATE_BITS-1:0] long_avg;
  logic [RATE_BITS-1:0] session_mean;
  logic [RATE_BITS-1:0] session_low;
  logic [RATE_BITS-1:0] session_high;
  logic                 stats_valid;

  modport source (output valid, output short_avg, output long_avg, output session_mean,
                  output session_low, output session_high, output stats_valid,
                  input ready);
  modport sink   (input valid, input short_avg, input long_avg, input session_mean,
                  input session_low, input session_high, input stats_valid,
                  output ready);
endinterface

// ----- hw/rtl/dema_ctrl.sv -----
// ----------------------------------------------------------------------------
// dema_ctrl
// Sequencer: accept; for a sample two shared-multiplier updates and bit-serial mean; result.
// ----------------------------------------------------------------------------
module dema_ctrl import dema_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      req_type,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dema_sts_t sts,
  output dema_cmd_t cmd
);

  dema_state_t state;
  dema_state_t state_next;
  logic        out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (req_type == REQ_CLEAR) ? ST_OUT : ST_MUL_S;
        end
      end
      ST_MUL_S: state_next = ST_MUL_L;
      ST_MUL_L: state_next = ST_UPD_L;
      ST_UPD_L: state_next = ST_DIV;
      ST_DIV: begin
        if (sts.div_last) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_MUL_S: cmd.mul_s    = 1'b1;
      ST_MUL_L: cmd.mul_l    = 1'b1;
      ST_UPD_L: cmd.upd_l    = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_OUT:   cmd.out_load = out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  // result register valid; a pending result does not block the next request
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- hw/rtl/dema_dp.sv -----
// ----------------------------------------------------------------------------
// dema_dp
// Datapath: alpha registers, moving averages, session statistics, divider.
// ----------------------------------------------------------------------------
module dema_dp import dema_pkg::*; #(
  parameter int RATE_BITS  = DEMA_RATE_BITS,
  parameter int COUNT_BITS = DEMA_COUNT_BITS,
  parameter int FRAC_BITS  = DEMA_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dema_cmd_t             cmd,
  output dema_sts_t             sts,
  input  logic                  req_type,
  input  logic [RATE_BITS-1:0]  sample_rate,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [RATE_BITS-1:0]  short_avg,
  output logic [RATE_BITS-1:0]  long_avg,
  output logic [RATE_BITS-1:0]  session_mean,
  output logic [RATE_BITS-1:0]  session_low,
  output logic [RATE_BITS-1:0]  session_high,
  output logic                  stats_valid
);

  localparam int ACC_W   = RATE_BITS + FRAC_BITS;
  localparam int SUM_W   = RATE_BITS + COUNT_BITS;
  localparam int DIFF_W  = ACC_W + 1;
  localparam int MULA_W  = CFG_DATA_W + 1;
  localparam int PROD_W  = DIFF_W + MULA_W;
  localparam int DCNT_W  = $clog2(RATE_BITS);

  localparam logic signed [PROD_W-1:0] ROUND_C = PROD_W'(ALPHA_HALF);
  localparam logic [ACC_W-1:0]         HALF_C  = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic [DCNT_W-1:0]        DCNT_TOP = DCNT_W'(RATE_BITS - 1);

  logic [CFG_DATA_W-1:0] alpha_short;
  logic [CFG_DATA_W-1:0] alpha_long;

  logic [ACC_W-1:0]      short_acc;
  logic [ACC_W-1:0]      long_acc;
  logic                  seen_any;
  logic                  first;
  logic [SUM_W-1:0]      sample_sum;
  logic [COUNT_BITS-1:0] sample_count;
  logic [RATE_BITS-1:0]  low_mark;
  logic [RATE_BITS-1:0]  high_mark;
  logic [RATE_BITS-1:0]  x_reg;

  logic signed [PROD_W-1:0] prod;
  logic [SUM_W-1:0]         rem;
  logic [RATE_BITS-1:0]     quot;
  logic [DCNT_W-1:0]        div_cnt;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_short <= ALPHA_SHORT_RST;
      alpha_long  <= ALPHA_LONG_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ALPHA_SHORT) begin
        alpha_short <= cfg_data;
      end
      if (cfg_index == CFG_ALPHA_LONG) begin
        alpha_long <= cfg_data;
      end
    end
  end

  // shared multiplier: acc' = acc + round(a * (X - acc) / 2^16)
  logic [CFG_DATA_W-1:0]    a_sel;
  logic [CFG_DATA_W-1:0]    a_eff;
  logic [ACC_W-1:0]         acc_sel;
  logic [ACC_W-1:0]         x_big;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod_comb;
  logic signed [PROD_W-1:0] step_full;
  logic [ACC_W-1:0]         acc_upd;
  logic [ACC_W-1:0]         acc_base;

  always_comb begin
    a_sel     = cmd.mul_s ? alpha_short : alpha_long;
    a_eff     = (a_sel > ALPHA_ONE) ? ALPHA_ONE : a_sel;
    acc_sel   = cmd.mul_s ? short_acc : long_acc;
    x_big     = {x_reg, {FRAC_BITS{1'b0}}};
    diff      = $signed({1'b0, x_big}) - $signed({1'b0, acc_sel});
    prod_comb = $signed({1'b0, a_eff}) * diff;
    step_full = (prod + ROUND_C) >>> ALPHA_BITS;
    acc_base  = cmd.mul_l ? short_acc : long_acc;
    // true result stays in range, so modular add is exact
    acc_upd   = acc_base + step_full[ACC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_s || cmd.mul_l) begin
      prod <= prod_comb;
    end
  end

  // bit-serial restoring divider; quotient always fits RATE_BITS
  logic [SUM_W-1:0] dvs;
  logic             dvs_fits;

  always_comb begin
    dvs      = SUM_W'(sample_count) << div_cnt;
    dvs_fits = rem >= dvs;
  end

  assign sts.div_last = (div_cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      short_acc    <= '0;
      long_acc     <= '0;
      seen_any     <= 1'b0;
      first        <= 1'b0;
      sample_sum   <= '0;
      sample_count <= '0;
      low_mark     <= '0;
      high_mark    <= '0;
      quot         <= '0;
      rem          <= '0;
      div_cnt      <= '0;
    end else begin
      if (cmd.take) begin
        if (req_type == REQ_CLEAR) begin
          short_acc    <= '0;
          long_acc     <= '0;
          seen_any     <= 1'b0;
          first        <= 1'b0;
          sample_sum   <= '0;
          sample_count <= '0;
          low_mark     <= '0;
          high_mark    <= '0;
          quot         <= '0;
        end else begin
          if (sample_count != '1) begin
            sample_sum   <= sample_sum + SUM_W'(sample_rate);
            sample_count <= sample_count + 1'b1;
          end
          if (!seen_any) begin
            low_mark  <= sample_rate;
            high_mark <= sample_rate;
            short_acc <= {sample_rate, {FRAC_BITS{1'b0}}};
            long_acc  <= {sample_rate, {FRAC_BITS{1'b0}}};
            seen_any  <= 1'b1;
            first     <= 1'b1;
          end else begin
            if (sample_rate < low_mark) begin
              low_mark <= sample_rate;
            end
            if (sample_rate > high_mark) begin
              high_mark <= sample_rate;
            end
            first <= 1'b0;
          end
        end
      end
      if (cmd.mul_s) begin
        rem     <= sample_sum;
        quot    <= '0;
        div_cnt <= DCNT_TOP;
      end
      // seeding sample keeps the seeded averages
      if (cmd.mul_l && !first) begin
        short_acc <= acc_upd;
      end
      if (cmd.upd_l && !first) begin
        long_acc <= acc_upd;
      end
      if (cmd.div_step) begin
        if (dvs_fits) begin
          rem           <= rem - dvs;
          quot[div_cnt] <= 1'b1;
        end
        if (div_cnt != '0) begin
          div_cnt <= div_cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && req_type == REQ_SAMPLE) begin
      x_reg <= sample_rate;
    end
  end

  // result register, averages rounded half up
  logic [ACC_W-1:0] short_rnd;
  logic [ACC_W-1:0] long_rnd;

  always_comb begin
    short_rnd = short_acc + HALF_C;
    long_rnd  = long_acc + HALF_C;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      short_avg    <= short_rnd[ACC_W-1:FRAC_BITS];
      long_avg     <= long_rnd[ACC_W-1:FRAC_BITS];
      session_mean <= quot;
      session_low  <= low_mark;
      session_high <= high_mark;
      stats_valid  <= seen_any;
    end
  end

endmodule

// ----- hw/rtl/dual_ema_rate_session_stats.sv -----
// ----------------------------------------------------------------------------
// dual_ema_rate_session_stats
// Short and long moving averages of frame-rate samples plus session
// mean, minimum and maximum.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   req_type, sample_rate
//   stats    out  valid/ready   short_avg, long_avg, session_mean,
//                               session_low, session_high, stats_valid
//   cfg      in   cfg_we        cfg_index, cfg_data
//
// A sample passes from transfer through the shared alpha multiplier states
// (MUL_S, MUL_L, UPD_L), then the restoring divider at one mean bit per
// cycle, then the result register. A clear goes straight to the result.
// One request is in flight at a time; a waiting result sits in the output
// register and does not block the next request transfer.
// Synchronous reset; no clearing pass.
// ----------------------------------------------------------------------------
module dual_ema_rate_session_stats import dema_pkg::*; #(
  parameter int RATE_BITS  = DEMA_RATE_BITS,
  parameter int COUNT_BITS = DEMA_COUNT_BITS,
  parameter int FRAC_BITS  = DEMA_FRAC_BITS
) (
  input logic                  clk,
  input logic                  rst,
  dema_req_if.sink             req,
  dema_stats_if.source         stats,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  dema_cmd_t cmd;
  dema_sts_t sts;

  dema_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .req_type  (req.req_type),
    .in_ready  (req.ready),
    .out_valid (stats.valid),
    .out_ready (stats.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dema_dp #(
    .RATE_BITS  (RATE_BITS),
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .req_type     (req.req_type),
    .sample_rate  (req.sample_rate),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .short_avg    (stats.short_avg),
    .long_avg     (stats.long_avg),
    .session_mean (stats.session_mean),
    .session_low  (stats.session_low),
    .session_high (stats.session_high),
    .stats_valid  (stats.stats_valid)
  );

endmodule
